>>> design/zmrp_pkg.sv
// ----------------------------------------------------------------------------
// Zone map range pruner package
// Shared types, codes and constants for the pruner front end, queue and back end.
// ----------------------------------------------------------------------------
package zmrp_pkg;

  localparam int ENTRY_INDEX_BITS_DEF = 16;
  localparam int QUEUE_DEPTH          = 2;
  localparam int QUEUE_PTR_BITS       = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_BITS       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [63:0] KEY_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_TERM  = 2'd1;
  localparam logic [1:0] OP_ZONE  = 2'd2;

  localparam logic [2:0] STRAT_LT = 3'd1;
  localparam logic [2:0] STRAT_LE = 3'd2;
  localparam logic [2:0] STRAT_EQ = 3'd3;
  localparam logic [2:0] STRAT_GE = 3'd4;
  localparam logic [2:0] STRAT_GT = 3'd5;

  typedef enum logic [2:0] {
    KIND_NOP,
    KIND_CLEAR,
    KIND_LT,
    KIND_LE,
    KIND_EQ,
    KIND_GE,
    KIND_GT,
    KIND_ZONE
  } kind_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [2:0]         strategy;
    logic               var_on_left;
    logic               term_usable;
    logic signed [63:0] key_value;
    logic signed [63:0] zone_min;
    logic signed [63:0] zone_max;
    logic               last_entry;
  } item_t;

  typedef struct packed {
    logic        overlaps;
    logic        bounds_present;
    logic        range_done;
    logic [16:0] first_block;
    logic [16:0] block_count;
    logic        prune_useful;
  } result_t;

  typedef struct packed {
    kind_t              kind;
    logic               last;
    logic               empty;
    logic signed [63:0] key;
    logic signed [63:0] zmin;
    logic signed [63:0] zmax;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

>>> design/zmrp_front.sv
// ----------------------------------------------------------------------------
// Zone map range pruner front end
// Accepts input transactions, mirrors and classifies them, and pushes commands.
// ----------------------------------------------------------------------------
module zmrp_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  zmrp_pkg::item_t   item,
  output logic              push_valid,
  output zmrp_pkg::cmd_t    push_cmd,
  input  zmrp_pkg::q_stat_t q_stat
);

  logic           held;
  logic           adv;
  logic [2:0]     strat;
  zmrp_pkg::cmd_t dec;

  assign adv        = !held || !q_stat.full;
  assign item_stall = !adv;
  assign push_valid = held && !q_stat.full;

  always_comb begin
    strat = item.strategy;
    if (!item.var_on_left) begin
      case (item.strategy)
        zmrp_pkg::STRAT_LT: strat = zmrp_pkg::STRAT_GT;
        zmrp_pkg::STRAT_LE: strat = zmrp_pkg::STRAT_GE;
        zmrp_pkg::STRAT_GE: strat = zmrp_pkg::STRAT_LE;
        zmrp_pkg::STRAT_GT: strat = zmrp_pkg::STRAT_LT;
        default:            strat = item.strategy;
      endcase
    end
  end

  always_comb begin
    dec       = '0;
    dec.kind  = zmrp_pkg::KIND_NOP;
    dec.last  = item.last_entry;
    dec.empty = (item.zone_min == zmrp_pkg::KEY_MAX);
    dec.key   = item.key_value;
    dec.zmin  = item.zone_min;
    dec.zmax  = item.zone_max;
    unique case (item.opcode)
      zmrp_pkg::OP_CLEAR: dec.kind = zmrp_pkg::KIND_CLEAR;
      zmrp_pkg::OP_ZONE:  dec.kind = zmrp_pkg::KIND_ZONE;
      zmrp_pkg::OP_TERM: begin
        if (item.term_usable) begin
          unique case (strat)
            zmrp_pkg::STRAT_LT: dec.kind = zmrp_pkg::KIND_LT;
            zmrp_pkg::STRAT_LE: dec.kind = zmrp_pkg::KIND_LE;
            zmrp_pkg::STRAT_EQ: dec.kind = zmrp_pkg::KIND_EQ;
            zmrp_pkg::STRAT_GE: dec.kind = zmrp_pkg::KIND_GE;
            zmrp_pkg::STRAT_GT: dec.kind = zmrp_pkg::KIND_GT;
            default:            dec.kind = zmrp_pkg::KIND_NOP;
          endcase
        end
      end
      default: dec.kind = zmrp_pkg::KIND_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (adv) begin
      held <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && item_valid) begin
      push_cmd <= dec;
    end
  end

endmodule

>>> design/zmrp_queue.sv
// ----------------------------------------------------------------------------
// Zone map range pruner command queue
// Short FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module zmrp_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  input  zmrp_pkg::cmd_t    push_cmd,
  output zmrp_pkg::q_stat_t q_stat,
  input  logic              pop,
  output zmrp_pkg::cmd_t    head
);

  zmrp_pkg::cmd_t                          slots [zmrp_pkg::QUEUE_DEPTH];
  logic [zmrp_pkg::QUEUE_PTR_BITS-1:0]     wr_ptr;
  logic [zmrp_pkg::QUEUE_PTR_BITS-1:0]     rd_ptr;
  logic [zmrp_pkg::QUEUE_CNT_BITS-1:0]     count;
  logic                                    do_push;
  logic                                    do_pop;

  assign q_stat.full  = (count == zmrp_pkg::QUEUE_CNT_BITS'(zmrp_pkg::QUEUE_DEPTH));
  assign q_stat.empty = (count == '0);
  assign do_push      = push_valid && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head         = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

>>> design/zmrp_back.sv
// ----------------------------------------------------------------------------
// Zone map range pruner back end
// Updates bounds and scan state per command, then forms the block range result.
// ----------------------------------------------------------------------------
module zmrp_back #(
  parameter int ENTRY_INDEX_BITS = zmrp_pkg::ENTRY_INDEX_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [31:0]       block_total,
  input  logic              cmd_valid,
  input  zmrp_pkg::cmd_t    cmd,
  output logic              cmd_pop,
  output logic              result_valid,
  input  logic              result_stall,
  output zmrp_pkg::result_t result
);

  typedef struct packed {
    logic        hit;
    logic        bp;
    logic        done;
    logic [31:0] fm;
    logic [31:0] lm;
  } ex_t;

  logic signed [63:0]          low_bound;
  logic signed [63:0]          high_bound;
  logic                        has_low;
  logic                        has_high;
  logic                        low_inclusive;
  logic                        high_inclusive;
  logic [ENTRY_INDEX_BITS-1:0] entry_index;
  logic [31:0]                 first_hit;
  logic [31:0]                 last_hit;

  logic signed [63:0]          low_bound_next;
  logic signed [63:0]          high_bound_next;
  logic                        has_low_next;
  logic                        has_high_next;
  logic                        low_inclusive_next;
  logic                        high_inclusive_next;

  logic                        ex_valid;
  ex_t                         ex;
  ex_t                         ex_next;
  logic                        out_adv;
  logic                        ex_adv;
  logic                        is_zone;
  logic                        hit;
  logic [31:0]                 blk;
  logic [31:0]                 fm_cur;
  logic [31:0]                 fm_new;
  logic [31:0]                 lm_new;

  logic                        no_match;
  logic [31:0]                 span;
  logic [31:0]                 cnt;
  logic [31:0]                 start;
  zmrp_pkg::result_t           fin;

  assign out_adv = !result_valid || !result_stall;
  assign ex_adv  = !ex_valid || out_adv;
  assign cmd_pop = ex_adv && cmd_valid;
  assign is_zone = (cmd.kind == zmrp_pkg::KIND_ZONE);

  always_comb begin
    low_bound_next      = low_bound;
    high_bound_next     = high_bound;
    has_low_next        = has_low;
    has_high_next       = has_high;
    low_inclusive_next  = low_inclusive;
    high_inclusive_next = high_inclusive;
    case (cmd.kind)
      zmrp_pkg::KIND_CLEAR: begin
        low_bound_next      = '0;
        high_bound_next     = '0;
        has_low_next        = 1'b0;
        has_high_next       = 1'b0;
        low_inclusive_next  = 1'b0;
        high_inclusive_next = 1'b0;
      end
      zmrp_pkg::KIND_EQ: begin
        low_bound_next      = cmd.key;
        high_bound_next     = cmd.key;
        has_low_next        = 1'b1;
        has_high_next       = 1'b1;
        low_inclusive_next  = 1'b1;
        high_inclusive_next = 1'b1;
      end
      zmrp_pkg::KIND_LT: begin
        if (!has_high || cmd.key < high_bound || (cmd.key == high_bound && high_inclusive)) begin
          high_bound_next     = cmd.key;
          has_high_next       = 1'b1;
          high_inclusive_next = 1'b0;
        end
      end
      zmrp_pkg::KIND_LE: begin
        if (!has_high || cmd.key < high_bound) begin
          high_bound_next     = cmd.key;
          has_high_next       = 1'b1;
          high_inclusive_next = 1'b1;
        end
      end
      zmrp_pkg::KIND_GT: begin
        if (!has_low || cmd.key > low_bound || (cmd.key == low_bound && low_inclusive)) begin
          low_bound_next     = cmd.key;
          has_low_next       = 1'b1;
          low_inclusive_next = 1'b0;
        end
      end
      zmrp_pkg::KIND_GE: begin
        if (!has_low || cmd.key > low_bound) begin
          low_bound_next     = cmd.key;
          has_low_next       = 1'b1;
          low_inclusive_next = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    hit = !cmd.empty;
    if (has_low && (low_inclusive ? (cmd.zmax < low_bound) : (cmd.zmax <= low_bound))) begin
      hit = 1'b0;
    end
    if (has_high && (high_inclusive ? (cmd.zmin > high_bound) : (cmd.zmin >= high_bound))) begin
      hit = 1'b0;
    end
    blk    = 32'(entry_index) + 32'd1;
    fm_cur = (entry_index == '0) ? block_total : first_hit;
    fm_new = (hit && (blk < fm_cur)) ? blk : fm_cur;
    lm_new = hit ? blk : last_hit;

    ex_next      = '0;
    ex_next.bp   = has_low_next || has_high_next;
    ex_next.hit  = is_zone && hit;
    ex_next.done = is_zone && cmd.last;
    ex_next.fm   = fm_new;
    ex_next.lm   = lm_new;
  end

  always_comb begin
    no_match = (ex.fm >= block_total);
    span     = ex.lm - ex.fm + 32'd1;
    cnt      = no_match ? 32'd0 : span;
    start    = no_match ? 32'd1 : ex.fm;

    fin                = '0;
    fin.overlaps       = ex.hit;
    fin.bounds_present = ex.bp;
    if (ex.done) begin
      fin.range_done   = 1'b1;
      fin.first_block  = start[16:0];
      fin.block_count  = cnt[16:0];
      fin.prune_useful = (cnt < block_total) && (block_total > 32'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      low_bound      <= '0;
      high_bound     <= '0;
      has_low        <= 1'b0;
      has_high       <= 1'b0;
      low_inclusive  <= 1'b0;
      high_inclusive <= 1'b0;
      entry_index    <= '0;
      first_hit      <= '0;
      last_hit       <= '0;
      ex_valid       <= 1'b0;
      result_valid   <= 1'b0;
    end else begin
      if (cmd_pop) begin
        low_bound      <= low_bound_next;
        high_bound     <= high_bound_next;
        has_low        <= has_low_next;
        has_high       <= has_high_next;
        low_inclusive  <= low_inclusive_next;
        high_inclusive <= high_inclusive_next;
        if (is_zone) begin
          if (cmd.last) begin
            entry_index <= '0;
            first_hit   <= block_total;
            last_hit    <= '0;
          end else begin
            entry_index <= entry_index + 1'b1;
            first_hit   <= fm_new;
            last_hit    <= lm_new;
          end
        end
      end
      if (ex_adv) begin
        ex_valid <= cmd_valid;
      end
      if (out_adv) begin
        result_valid <= ex_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      ex <= ex_next;
    end
    if (out_adv && ex_valid) begin
      result <= fin;
    end
  end

endmodule

>>> design/zone_map_range_pruner_top.sv
// Zone map range pruner. Every input transaction (clear bounds, predicate
// term or zone map entry) gives exactly one result transaction. The block
// sustains one transaction per clock while result_stall is low; the rate is set
// by the execute stage of the back end, which updates the key bounds and the
// scan range for one item at a time. When nothing stalls, an accepted item
// passes through the front register, the command queue, the execute stage and
// the result register in that order, and the result register presents it.
// Write the block total register only while no transaction is in flight.
// ----------------------------------------------------------------------------
// Zone map range pruner top level
// Connects front end, command queue and back end, and holds the config register.
// ----------------------------------------------------------------------------
module zone_map_range_pruner_top #(
  parameter int ENTRY_INDEX_BITS = zmrp_pkg::ENTRY_INDEX_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  zmrp_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output zmrp_pkg::result_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [31:0]       cfg_data
);

  logic [31:0]       block_total;
  logic              push_valid;
  zmrp_pkg::cmd_t    push_cmd;
  zmrp_pkg::q_stat_t q_stat;
  logic              cmd_pop;
  zmrp_pkg::cmd_t    head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_total <= '0;
    end else if (cfg_valid && cfg_ready) begin
      block_total <= cfg_data;
    end
  end

  zmrp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .q_stat     (q_stat)
  );

  zmrp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .q_stat     (q_stat),
    .pop        (cmd_pop),
    .head       (head)
  );

  zmrp_back #(
    .ENTRY_INDEX_BITS (ENTRY_INDEX_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .block_total  (block_total),
    .cmd_valid    (!q_stat.empty),
    .cmd          (head),
    .cmd_pop      (cmd_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  a_range_fields_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.range_done |->
      result.first_block == '0 && result.block_count == '0 && !result.prune_useful)
    else $error("range fields set without range_done");

  a_useful_needs_blocks: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.prune_useful |-> block_total > 32'd1)
    else $error("prune_useful with block total below two");

  a_quiet_after_reset: assert property (@(posedge clk)
    !rst && $past(rst) |-> !result_valid)
    else $error("result valid right after reset");

  a_queue_accounting: assert property (@(posedge clk) disable iff (rst)
    q_stat.full |-> !q_stat.empty)
    else $error("queue reports full and empty together");

endmodule
